### src/pte_pkg.sv
// pte_pkg: command codes, sequencer states, the control struct and mask and
// bit-reverse helpers shared by the tile edit engine modules. No dependencies.
`timescale 1ns / 1ps
package pte_pkg;

    typedef enum logic [3:0] {
        OP_MIRROR   = 4'd0,
        OP_VFLIP    = 4'd1,
        OP_RECOLOR  = 4'd2,
        OP_HROTATE  = 4'd3,
        OP_VROTATE  = 4'd4,
        OP_AND      = 4'd5,
        OP_OR       = 4'd6,
        OP_XOR      = 4'd7,
        OP_COPY     = 4'd8,
        OP_COMPARE  = 4'd9,
        OP_FILL     = 4'd10,
        OP_XORRECT  = 4'd11,
        OP_READROW  = 4'd12,
        OP_WRITEROW = 4'd13
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_WAIT,
        ST_WR,
        ST_OUT
    } t_state;

    // Control from sequencer to byte unit.
    typedef struct packed {
        logic       load_a;   // capture read data as first operand
        logic       load_b;   // capture read data as second operand
        logic       clr;      // clear compare flag
    } t_unit_ctl;

    localparam logic [7:0] FULL_MASK  = 8'hFF;
    localparam logic [7:0] SHORT_MASK = 8'h7F;

    function automatic logic [7:0] bit_rev(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = b[i];
        end
        return r;
    endfunction

endpackage

### src/pte_byte_unit.sv
// pte_byte_unit: the shared byte operator. Holds operand registers, produces
// the new byte for each command and accumulates the compare flag. Uses pte_pkg.
`timescale 1ns / 1ps
module pte_byte_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pte_pkg::t_unit_ctl i_ctl,
    input  pte_pkg::t_op      i_op,
    input  logic [7:0]        i_rdata,
    input  logic [7:0]        i_mask,
    input  logic [1:0]        i_color,
    input  logic [7:0]        i_color_map,
    input  logic              i_plane,
    input  logic              i_row_hit,
    input  logic [7:0]        i_wdata_in,
    output logic [7:0]        o_a,
    output logic [7:0]        o_result,
    output logic              o_differs
);

    logic [7:0] r_a, r_b;
    logic       r_diff;
    logic [7:0] n_res;
    logic [7:0] v_col;
    logic [1:0] c, nc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_a) r_a <= i_rdata;
        if (i_ctl.load_b) r_b <= i_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_diff <= 1'b0;
        end else if (i_ctl.load_b && i_op == pte_pkg::OP_COMPARE && i_rdata != r_a) begin
            r_diff <= 1'b1;
        end
    end

    always_comb begin
        v_col = (i_plane ? i_color[1] : i_color[0]) ? i_mask : 8'h00;
        n_res = r_a;
        c     = '0;
        nc    = '0;
        case (i_op)
            pte_pkg::OP_MIRROR:  n_res = pte_pkg::bit_rev(r_a);
            pte_pkg::OP_HROTATE: n_res = {r_a[6:0], r_a[7]};
            pte_pkg::OP_AND:     n_res = r_a & r_b;
            pte_pkg::OP_OR:      n_res = r_a | r_b;
            pte_pkg::OP_XOR:     n_res = r_a ^ r_b;
            pte_pkg::OP_COPY:    n_res = r_b;
            pte_pkg::OP_FILL:    n_res = i_row_hit ? ((r_a & ~i_mask) | v_col) : r_a;
            pte_pkg::OP_XORRECT: n_res = i_row_hit ? (r_a ^ v_col) : r_a;
            pte_pkg::OP_WRITEROW: n_res = i_wdata_in;
            pte_pkg::OP_RECOLOR: begin
                // r_a is plane 0, r_b plane 1 of the same row
                for (int i = 0; i < 8; i++) begin
                    c  = {r_b[i], r_a[i]};
                    nc = i_color_map[{c, 1'b0} +: 2];
                    n_res[i] = i_plane ? nc[1] : nc[0];
                end
            end
            default: n_res = r_a;
        endcase
    end

    assign o_a       = r_a;
    assign o_result  = n_res;
    assign o_differs = r_diff;

endmodule

### src/pte_tile_ram.sv
// pte_tile_ram: byte-wide tile store, one read and one write port, read data
// registered. No dependencies.
`timescale 1ns / 1ps
module pte_tile_ram #(
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [0:(1 << ADDR_W) - 1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/planar_tile_edit_engine_unit.sv
// planar_tile_edit_engine_unit: top level. Sequencer walking the 16 bytes of
// a tile through pte_byte_unit and pte_tile_ram. Uses pte_pkg.
//
//   channel  dir  word
//   s_axis   in   command fields (see i_s_axis_tdata)
//   m_axis   out  differs, plane0_out, plane1_out
//
// A byte step is read, wait, write, with a second read state when a second
// operand is read; an accept state and an output state come on top.
// vflip/vrotate make a copy pass into a buffer, then a write pass; in recolor
// plane 1 reuses the plane 0 operands; readrow/writerow touch one row of each
// plane; op 14/15 go from the first read state straight to output.
// Synchronous active-low reset clears the sequencer and the compare flag; the
// store is not cleared. The result waits in the output state until taken.
`timescale 1ns / 1ps
module planar_tile_edit_engine_unit #(
    parameter int TILE_COUNT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // op[3:0] dst_tile[15:4] src_tile[27:16] x_left[30:28] x_right[33:31]
    // y_top[36:34] y_bottom[39:37] color[41:40] color_map[49:42] row[52:50]
    // plane0_in[60:53] plane1_in[68:61], zero to 72
    input  logic [71:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // differs[0] plane0_out[8:1] plane1_out[16:9], zero to 24
    output logic [23:0] o_m_axis_tdata
);

    localparam int TW = $clog2(TILE_COUNT);
    localparam int AW = TW + 4;

    pte_pkg::t_state r_state, n_state;
    logic [71:0] r_cmd;
    logic [3:0]  r_idx;
    logic [7:0]  r_p0, r_p1;
    logic        r_last;

    pte_pkg::t_op op;
    logic [TW-1:0] dst, src;
    logic [2:0] xl, xr, yt, yb, rowf;
    logic [1:0] colr;
    logic [7:0] cmap, pin0, pin1;

    assign op   = pte_pkg::t_op'(r_cmd[3:0]);
    assign dst  = r_cmd[4 +: TW];
    assign src  = r_cmd[16 +: TW];
    assign xl   = r_cmd[30:28];
    assign xr   = r_cmd[33:31];
    assign yt   = r_cmd[36:34];
    assign yb   = r_cmd[39:37];
    assign colr = r_cmd[41:40];
    assign cmap = r_cmd[49:42];
    assign rowf = r_cmd[52:50];
    assign pin0 = r_cmd[60:53];
    assign pin1 = r_cmd[68:61];

    // Byte index r_idx: bit 3 plane, low bits row. Recolor walks both planes
    // of one row back to back: bit 0 plane, high bits row.
    logic       plane;
    logic [2:0] yrow;
    logic [3:0] idx_a, idx_b, idx_w;
    logic       two_rd, single, recolor;
    logic [AW-1:0] raddr, waddr;
    logic       we;
    logic [7:0] rdata, res, opa, wdata;
    logic       diff;
    pte_pkg::t_unit_ctl ctl;
    logic [7:0] mask;
    logic       row_hit;

    assign single  = (op == pte_pkg::OP_READROW) || (op == pte_pkg::OP_WRITEROW);
    assign recolor = (op == pte_pkg::OP_RECOLOR);
    assign plane   = recolor ? r_idx[0] : r_idx[3];
    assign yrow    = single ? rowf : (recolor ? r_idx[3:1] : r_idx[2:0]);
    assign mask    = (pte_pkg::FULL_MASK >> xl) ^ (pte_pkg::SHORT_MASK >> xr);
    assign row_hit = (yrow >= yt) && (yrow <= yb);

    always_comb begin
        two_rd = 1'b0;
        idx_a  = {plane, yrow};
        idx_b  = {plane, yrow};
        idx_w  = {plane, yrow};
        case (op)
            pte_pkg::OP_AND, pte_pkg::OP_OR, pte_pkg::OP_XOR,
            pte_pkg::OP_COPY, pte_pkg::OP_COMPARE: two_rd = 1'b1;
            pte_pkg::OP_RECOLOR: begin
                two_rd = 1'b1;
                idx_a  = {1'b0, yrow};
                idx_b  = {1'b1, yrow};
            end
            pte_pkg::OP_VFLIP: idx_a = {plane, 3'd7 - yrow};
            pte_pkg::OP_VROTATE: idx_a = {plane, yrow - 3'd1};
            default: two_rd = 1'b0;
        endcase
    end

    // vflip and vrotate read a different row than they write; a staging
    // buffer of the old tile keeps the in-place result correct.
    logic [7:0] r_buf [0:15];
    logic       buffered;
    assign buffered = (op == pte_pkg::OP_VFLIP) || (op == pte_pkg::OP_VROTATE);
    logic       r_pass;   // pass 0: copy tile into buffer

    always_comb begin
        if (r_state == pte_pkg::ST_RD_B && op != pte_pkg::OP_RECOLOR)
            raddr = {src, idx_b};
        else if (r_state == pte_pkg::ST_RD_B)
            raddr = {dst, idx_b};
        else if (buffered && !r_pass)
            raddr = {dst, r_idx};
        else
            raddr = {dst, idx_a};
    end

    assign waddr = {dst, idx_w};
    assign wdata = buffered ? r_buf[idx_a] :
                   (op == pte_pkg::OP_WRITEROW) ? (plane ? pin1 : pin0) : res;
    assign we = (r_state == pte_pkg::ST_WR) && op != pte_pkg::OP_COMPARE
             && op != pte_pkg::OP_READROW && (!buffered || r_pass);

    pte_tile_ram #(.ADDR_W(AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    pte_byte_unit u_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_op       (op),
        .i_rdata    (rdata),
        .i_mask     (mask),
        .i_color    (colr),
        .i_color_map(cmap),
        .i_plane    (plane),
        .i_row_hit  (row_hit),
        .i_wdata_in (8'h00),
        .o_a        (opa),
        .o_result   (res),
        .o_differs  (diff)
    );

    // Operand capture strobes are registered from the read states, so they meet the registered read data.
    logic r_cap_a, r_cap_b;
    assign ctl.load_a = r_cap_a;
    assign ctl.load_b = r_cap_b;
    assign ctl.clr    = (r_state == pte_pkg::ST_IDLE);

    logic valid_op;
    assign valid_op = r_cmd[3:0] <= pte_pkg::OP_WRITEROW;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pte_pkg::ST_IDLE:
                if (i_s_axis_tvalid) n_state = pte_pkg::ST_RD_A;
            pte_pkg::ST_RD_A:
                if (!valid_op) n_state = pte_pkg::ST_OUT;
                else if (two_rd && !(buffered && !r_pass)) n_state = pte_pkg::ST_RD_B;
                else n_state = pte_pkg::ST_WAIT;
            pte_pkg::ST_RD_B: n_state = pte_pkg::ST_WAIT;
            pte_pkg::ST_WAIT: n_state = pte_pkg::ST_WR;
            pte_pkg::ST_WR:
                if (r_last) n_state = pte_pkg::ST_OUT;
                // plane 1 of a recolor row reuses the held operands
                else if (recolor && !plane) n_state = pte_pkg::ST_WR;
                else n_state = pte_pkg::ST_RD_A;
            pte_pkg::ST_OUT:
                if (i_m_axis_tready) n_state = pte_pkg::ST_IDLE;
            default: n_state = pte_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        r_last = 1'b0;
        if (single) r_last = r_idx == 4'd8;
        else if (buffered) r_last = r_pass && (r_idx == 4'd15);
        else r_last = r_idx == 4'd15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pte_pkg::ST_IDLE;
            r_cap_a <= 1'b0;
            r_cap_b <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cap_a <= r_state == pte_pkg::ST_RD_A && valid_op;
            r_cap_b <= r_state == pte_pkg::ST_RD_B;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pte_pkg::ST_IDLE) begin
            r_cmd  <= i_s_axis_tdata;
            r_idx  <= '0;
            r_pass <= 1'b0;
            r_p0   <= '0;
            r_p1   <= '0;
        end else if (r_state == pte_pkg::ST_WR) begin
            if (buffered && !r_pass) r_buf[r_idx] <= opa;
            if (op == pte_pkg::OP_READROW) begin
                if (plane) r_p1 <= opa;
                else       r_p0 <= opa;
            end
            if (single) r_idx <= 4'd8;
            else begin
                r_idx <= r_idx + 4'd1;
                if (r_idx == 4'd15) r_pass <= 1'b1;
            end
        end
    end

    assign o_s_axis_tready = r_state == pte_pkg::ST_IDLE;
    assign o_m_axis_tvalid = r_state == pte_pkg::ST_OUT;
    assign o_m_axis_tdata  = {7'd0, r_p1, r_p0, diff & (op == pte_pkg::OP_COMPARE)};

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid)) else $error("ready during output");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !we) else $error("write while idle");
    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready) |=> o_s_axis_tready)
        else $error("no return to idle");
`endif

endmodule

### verif/planar_tile_edit_engine_unit_tb.sv
// planar_tile_edit_engine_unit_tb: self-checking bench for the tile edit engine.
// It predicts every result word from its own tile store copy. Uses pte_pkg.
`timescale 1ns / 1ps
module planar_tile_edit_engine_unit_tb;

    localparam logic [3:0] OP_SPARE_LO = 4'd14;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;
    localparam int POOL_SIZE = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic [7:0]  plane1_in;
        logic [7:0]  plane0_in;
        logic [2:0]  row;
        logic [7:0]  color_map;
        logic [1:0]  color;
        logic [2:0]  y_bottom;
        logic [2:0]  y_top;
        logic [2:0]  x_right;
        logic [2:0]  x_left;
        logic [11:0] src_tile;
        logic [11:0] dst_tile;
        logic [3:0]  op;
    } t_cmd;

    typedef struct packed {
        logic [7:0] plane1_out;
        logic [7:0] plane0_out;
        logic       differs;
    } t_row_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // op dst_tile src_tile x_left x_right y_top y_bottom color color_map row
    // plane0_in plane1_in, zero to 72
    logic [71:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // differs plane0_out plane1_out, zero to 24
    logic [23:0] o_m_axis_tdata;

    planar_tile_edit_engine_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    logic [7:0]  tile_mem [0:65535];
    logic [7:0]  rows_written [0:4095];
    logic [11:0] tile_pool [0:POOL_SIZE-1];
    t_row_result pending_results[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          rx_mode = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Apply one command to the shadow store and return its result word.
    function automatic t_row_result apply_cmd(t_cmd c);
        t_row_result r;
        logic [7:0]  m, v0, v1, a, b, n0, n1;
        logic [1:0]  pix, nc;
        int          base, sbase;
        r = '0;
        base = int'({c.dst_tile, 4'd0});
        sbase = int'({c.src_tile, 4'd0});
        case (c.op)
            pte_pkg::OP_MIRROR:
                for (int i = 0; i < 16; i++) begin
                    for (int k = 0; k < 8; k++) a[7 - k] = tile_mem[base + i][k];
                    tile_mem[base + i] = a;
                end
            pte_pkg::OP_VFLIP:
                for (int y = 0; y < 4; y++) begin
                    for (int p = 0; p < 16; p += 8) begin
                        a = tile_mem[base + p + y];
                        tile_mem[base + p + y] = tile_mem[base + p + 7 - y];
                        tile_mem[base + p + 7 - y] = a;
                    end
                end
            pte_pkg::OP_RECOLOR:
                for (int y = 0; y < 8; y++) begin
                    for (int k = 0; k < 8; k++) begin
                        pix = {tile_mem[base + 8 + y][k], tile_mem[base + y][k]};
                        nc = c.color_map[2 * pix +: 2];
                        n0[k] = nc[0];
                        n1[k] = nc[1];
                    end
                    tile_mem[base + y] = n0;
                    tile_mem[base + 8 + y] = n1;
                end
            pte_pkg::OP_HROTATE:
                for (int i = 0; i < 16; i++)
                    tile_mem[base + i] = {tile_mem[base + i][6:0], tile_mem[base + i][7]};
            pte_pkg::OP_VROTATE: begin
                a = tile_mem[base + 7];
                b = tile_mem[base + 15];
                for (int y = 7; y > 0; y--) begin
                    tile_mem[base + y] = tile_mem[base + y - 1];
                    tile_mem[base + 8 + y] = tile_mem[base + 7 + y];
                end
                tile_mem[base] = a;
                tile_mem[base + 8] = b;
            end
            pte_pkg::OP_AND, pte_pkg::OP_OR, pte_pkg::OP_XOR, pte_pkg::OP_COPY:
                for (int i = 0; i < 16; i++) begin
                    a = tile_mem[base + i];
                    b = tile_mem[sbase + i];
                    case (c.op)
                        pte_pkg::OP_AND:  tile_mem[base + i] = a & b;
                        pte_pkg::OP_OR:   tile_mem[base + i] = a | b;
                        pte_pkg::OP_XOR:  tile_mem[base + i] = a ^ b;
                        default:          tile_mem[base + i] = b;
                    endcase
                end
            pte_pkg::OP_COMPARE:
                for (int i = 0; i < 16; i++)
                    if (tile_mem[base + i] != tile_mem[sbase + i]) r.differs = 1'b1;
            pte_pkg::OP_FILL, pte_pkg::OP_XORRECT: begin
                m = (pte_pkg::FULL_MASK >> c.x_left) ^ (pte_pkg::SHORT_MASK >> c.x_right);
                v0 = c.color[0] ? m : 8'h00;
                v1 = c.color[1] ? m : 8'h00;
                for (int y = c.y_top; y <= c.y_bottom; y++) begin
                    if (c.op == pte_pkg::OP_FILL) begin
                        tile_mem[base + y] = (tile_mem[base + y] & ~m) | v0;
                        tile_mem[base + 8 + y] = (tile_mem[base + 8 + y] & ~m) | v1;
                    end else begin
                        tile_mem[base + y] ^= v0;
                        tile_mem[base + 8 + y] ^= v1;
                    end
                end
            end
            pte_pkg::OP_READROW: begin
                r.plane0_out = tile_mem[base + c.row];
                r.plane1_out = tile_mem[base + 8 + c.row];
            end
            pte_pkg::OP_WRITEROW: begin
                tile_mem[base + c.row] = c.plane0_in;
                tile_mem[base + 8 + c.row] = c.plane1_in;
                rows_written[c.dst_tile][c.row] = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Drive one command word, hold it until accepted, then log its result.
    task automatic send_cmd(t_cmd c);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {3'd0, c};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(apply_cmd(c));
    endtask

    function automatic t_cmd random_fields();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[68:0];
    endfunction

    function automatic logic [11:0] pick_tile();
        return tile_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic test_init_pool();
        t_cmd c;
        foreach (tile_pool[k]) begin
            for (int y = 0; y < 8; y++) begin
                c = random_fields();
                c.op = pte_pkg::OP_WRITEROW;
                c.dst_tile = tile_pool[k];
                c.row = 3'(y);
                send_cmd(c);
            end
        end
    endtask

    task automatic test_directed();
        t_cmd c;
        // every command once on the extreme tiles
        for (int op = 0; op < 16; op++) begin
            c = random_fields();
            c.op = 4'(op);
            c.dst_tile = 12'hFFF;
            c.src_tile = 12'h000;
            send_cmd(c);
        end
        // source equal to destination
        c = random_fields(); c.op = pte_pkg::OP_XOR; c.dst_tile = 12'h000;
        c.src_tile = 12'h000;
        send_cmd(c);
        c.op = pte_pkg::OP_COMPARE; send_cmd(c);
        // full-tile fill, reversed columns, empty column range, then reversed rows
        c = random_fields(); c.op = pte_pkg::OP_FILL; c.dst_tile = 12'hFFF;
        c.x_left = 0; c.x_right = 7; c.y_top = 0; c.y_bottom = 7; c.color = 2'd3;
        send_cmd(c);
        c.op = pte_pkg::OP_XORRECT; c.x_left = 7; c.x_right = 0; c.color = 2'd2;
        send_cmd(c);
        c.x_left = 4; c.x_right = 3; send_cmd(c);
        c.op = pte_pkg::OP_FILL; c.x_left = 0; c.x_right = 7; c.y_top = 6; c.y_bottom = 1;
        send_cmd(c);
        c = random_fields(); c.op = pte_pkg::OP_RECOLOR; c.dst_tile = 12'hFFF;
        c.color_map = 8'h1B;
        send_cmd(c);
        c = random_fields(); c.op = pte_pkg::OP_READROW; c.dst_tile = 12'hFFF; c.row = 7;
        send_cmd(c);
        c.row = 0; send_cmd(c);
    endtask

    task automatic test_random(int count);
        t_cmd c;
        int   sel;
        for (int n = 0; n < count; n++) begin
            if (n % 250 == 0) rx_mode = $urandom_range(0, 3);
            c = random_fields();
            sel = $urandom_range(0, 99);
            if (sel < 3) begin
                c.op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
            end else if (sel < 10) begin
                // write anywhere; such tiles only get read back row by row
                c.op = pte_pkg::OP_WRITEROW;
            end else begin
                c.op = 4'($urandom_range(0, 13));
                c.dst_tile = pick_tile();
                c.src_tile = pick_tile();
                if (c.op == pte_pkg::OP_READROW && $urandom_range(0, 1)) begin
                    c.dst_tile = 12'($urandom);
                    if (!rows_written[c.dst_tile][c.row]) c.dst_tile = pick_tile();
                end
            end
            send_cmd(c);
        end
    endtask

    // Receiver stall pattern, mode switched by the random test.
    always @(posedge i_clk) begin
        case (rx_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_axis_tready <= (cycle_count % 7 < 3);
        endcase
    end

    always @(posedge i_clk) begin
        t_row_result got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[16:0];
            if (pending_results.size() == 0) begin
                $error("unexpected result word %h", o_m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.differs != want.differs) begin
                    $error("differs: expected %0d, got %0d", want.differs, got.differs);
                    error_count++;
                end
                if (got.plane0_out != want.plane0_out) begin
                    $error("plane0_out: expected %h, got %h", want.plane0_out, got.plane0_out);
                    error_count++;
                end
                if (got.plane1_out != want.plane1_out) begin
                    $error("plane1_out: expected %h, got %h", want.plane1_out, got.plane1_out);
                    error_count++;
                end
                if (o_m_axis_tdata[23:17] != '0) begin
                    $error("pad bits: expected 0, got %h", o_m_axis_tdata[23:17]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        foreach (rows_written[k]) rows_written[k] = '0;
        tile_pool[0] = 12'h000;
        tile_pool[1] = 12'hFFF;
        tile_pool[2] = 12'hAAA;
        tile_pool[3] = 12'h555;
        for (int k = 4; k < POOL_SIZE; k++) tile_pool[k] = 12'($urandom);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_init_pool();
        test_directed();
        test_random(1150);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
src/pte_pkg.sv
src/pte_byte_unit.sv
src/pte_tile_ram.sv
src/planar_tile_edit_engine_unit.sv
verif/planar_tile_edit_engine_unit_tb.sv
